// ===== design/gdate_pkg.sv =====
// Constants and month lookup for the day-number to Gregorian date converter.
package gdate_pkg;

  localparam int unsigned IN_W   = 32;
  localparam int unsigned OUT_W  = 40;
  localparam int unsigned YEAR_W = 24;

  // Base day of 1 Jan year 0 folded with a bias of 14712 400-year cycles,
  // so that the shifted day count is never negative.
  localparam logic [33:0]        BASE_OFF   = 34'd2147658004;
  localparam logic signed [15:0] CYC_BIAS   = 16'sd14712;

  localparam logic [24:0] RECIP_400Y = 25'd30103605;  // floor(2^42 / 146097)
  localparam logic [15:0] RECIP_4Y   = 16'd45934;     // ceil(2^26 / 1461)

  localparam logic [17:0] DAYS_400Y    = 18'd146097;
  localparam logic [17:0] DAYS_100Y    = 18'd36524;
  localparam logic [10:0] DAYS_4Y      = 11'd1461;
  localparam logic [10:0] DAYS_1Y      = 11'd365;
  localparam logic [5:0]  LEAP_MARCH   = 6'd60;
  localparam logic [5:0]  COMMON_MARCH = 6'd59;
  localparam logic [5:0]  DAYS_JAN     = 6'd31;

  // Days before each month of a common year, indexed by month number.
  localparam logic [8:0] DAYS_BEFORE [16] = '{
    9'd0, 9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
    9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365, 9'd365, 9'd365
  };

  function automatic logic [3:0] month_of(input logic [8:0] doy);
    logic [3:0] mon;
    mon = 4'd1;
    for (int m = 2; m <= 12; m++) begin
      if (doy >= DAYS_BEFORE[m]) begin
        mon = 4'(m);
      end
    end
    return mon;
  endfunction

endpackage

// ===== design/gregorian_date_from_day_number.sv =====
// Pipelined Julian day number to proleptic Gregorian date converter.
//
//  port group | dir | word layout (low bit up)
//  in_*       | in  | tdata[31:0] day_number (signed)
//  out_*      | out | tdata[23:0] year (signed), [27:24] month, [32:28] day, [39:33] zero
//
// Nine register stages: bias add, 400-year reciprocal multiply, back-multiply,
// remainder fix-up, century split, 4-year reciprocal multiply, 4-year split,
// year split, month lookup. One word per cycle while the output is not stalled.
// rst_n (synchronous, active low) clears the valid bits and the input skid.
// An output stall freezes all stages; one more input word parks in the skid
// register, so in_tready comes from a flop only.
module gregorian_date_from_day_number (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [gdate_pkg::IN_W-1:0]  in_tdata,   // day_number[31:0]
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [gdate_pkg::OUT_W-1:0] out_tdata   // year[23:0], month[27:24], day[32:28]
);
  import gdate_pkg::*;

  logic en;
  logic skid_full_r, skid_full_nxt;
  logic [IN_W-1:0] skid_r;
  logic src_valid;
  logic [IN_W-1:0] src_data;

  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r, v8_r, out_tvalid_r;

  // stage payloads
  logic [32:0] e1_r, e2_r, e3_r, p3_r;
  logic [32:0] e1_nxt, p3_nxt;
  logic [14:0] qe2_r, qe3_r, qe2_nxt;
  logic [47:0] prod2;
  logic [17:0] d0_4_r, d0_4_nxt;
  logic signed [15:0] q4_r, q4_nxt;
  logic [32:0] diff4;
  logic [18:0] rem4;
  logic        over4;
  logic [14:0] qc4;

  logic [YEAR_W-1:0] y5_r, y6_r, y7_r, y8_r;
  logic [YEAR_W-1:0] y5_nxt, y6_nxt, y7_nxt, y8_nxt, qs5;
  logic        x5_r, x6_r, x7_r, x8_r;
  logic        x5_nxt, x6_nxt, x7_nxt;
  logic [5:0]  ed5_r, ed6_r, ed7_r, ed8_r;
  logic [5:0]  ed6_nxt, ed7_nxt;
  logic [1:0]  c5_r, c5_nxt;
  logic [15:0] d2_5_r, d2_5_nxt, d2_6_r, d2m1_6;
  logic [17:0] d2_full5;
  logic [31:0] pr6_r, pr6_nxt;
  logic [8:0]  c100_6;
  logic [4:0]  c4_7;
  logic [10:0] r2_7, d3_7_r, d3_7_nxt;
  logic [1:0]  c1_8;
  logic [10:0] r3_full8;
  logic [8:0]  r3_8_r, r3_8_nxt;

  logic [3:0] month9;
  logic [4:0] day9;
  logic [8:0] day_full9;
  logic [OUT_W-1:0] out_tdata_r, out_tdata_nxt;

  assign en        = !out_tvalid_r || out_tready;
  assign in_tready = !skid_full_r;
  assign src_valid = skid_full_r || in_tvalid;
  assign src_data  = skid_full_r ? skid_r : in_tdata;

  always_comb begin
    skid_full_nxt = skid_full_r;
    if (en) begin
      skid_full_nxt = 1'b0;
    end else if (in_tvalid && !skid_full_r) begin
      skid_full_nxt = 1'b1;
    end
  end

  // S1: shift the day count onto a non-negative range
  assign e1_nxt = 33'({{2{src_data[IN_W-1]}}, src_data} + BASE_OFF);

  // S2: quotient estimate, low by at most one
  assign prod2   = 48'(e1_r[32:10]) * 48'(RECIP_400Y);
  assign qe2_nxt = prod2[46:32];

  // S3: back-multiply
  assign p3_nxt = 33'(qe2_r) * 33'(DAYS_400Y);

  // S4: remainder and one correction step
  assign diff4    = e3_r - p3_r;
  assign rem4     = diff4[18:0];
  assign over4    = rem4 >= 19'(DAYS_400Y);
  assign d0_4_nxt = over4 ? 18'(rem4 - 19'(DAYS_400Y)) : rem4[17:0];
  assign qc4      = qe3_r + 15'(over4);
  assign q4_nxt   = signed'({1'b0, qc4}) - CYC_BIAS;

  // S5: 400-year base year, century split
  assign qs5    = {{(YEAR_W-16){q4_r[15]}}, q4_r};
  assign y5_nxt = (qs5 << 8) + (qs5 << 7) + (qs5 << 4);
  assign x5_nxt = d0_4_r < 18'(LEAP_MARCH);
  always_comb begin
    if (d0_4_r >= 18'd109573) begin
      c5_nxt = 2'd3;
    end else if (d0_4_r >= 18'd73049) begin
      c5_nxt = 2'd2;
    end else if (d0_4_r >= 18'd36525) begin
      c5_nxt = 2'd1;
    end else begin
      c5_nxt = 2'd0;
    end
  end
  // day count inside the century, plus one (the 4-year split input)
  assign d2_full5 = d0_4_r - 18'(c5_nxt) * DAYS_100Y;
  assign d2_5_nxt = d2_full5[15:0];

  // S6: century years, 4-year reciprocal multiply
  assign c100_6  = 9'(c5_r) * 9'd100;
  assign y6_nxt  = x5_r ? y5_r : y5_r + YEAR_W'(c100_6);
  assign d2m1_6  = d2_5_r - 16'd1;
  assign x6_nxt  = x5_r || (d2_5_r < 16'(LEAP_MARCH));
  assign ed6_nxt = x5_r ? ed5_r : d2m1_6[5:0];
  assign pr6_nxt = 32'(d2_5_r) * 32'(RECIP_4Y);

  // S7: 4-year split
  assign c4_7     = pr6_r[30:26];
  assign r2_7     = 11'(d2_6_r - 16'(c4_7) * 16'(DAYS_4Y));
  assign y7_nxt   = x6_r ? y6_r : y6_r + YEAR_W'({c4_7, 2'b00});
  assign x7_nxt   = x6_r || (r2_7 < 11'(LEAP_MARCH));
  assign ed7_nxt  = x6_r ? ed6_r : r2_7[5:0];
  assign d3_7_nxt = r2_7 - 11'd1;

  // S8: single-year split
  always_comb begin
    if (d3_7_r >= 11'd1095) begin
      c1_8 = 2'd3;
    end else if (d3_7_r >= 11'd730) begin
      c1_8 = 2'd2;
    end else if (d3_7_r >= DAYS_1Y) begin
      c1_8 = 2'd1;
    end else begin
      c1_8 = 2'd0;
    end
  end
  assign r3_full8 = d3_7_r - 11'(c1_8) * DAYS_1Y;
  assign r3_8_nxt = r3_full8[8:0];
  assign y8_nxt   = x7_r ? y7_r : y7_r + YEAR_W'(c1_8);

  // S9: month and day; early exits land in January or February
  always_comb begin
    if (x8_r) begin
      if (ed8_r < DAYS_JAN) begin
        month9 = 4'd1;
        day9   = 5'(ed8_r + 6'd1);
      end else begin
        month9 = 4'd2;
        day9   = 5'(ed8_r - (DAYS_JAN - 6'd1));
      end
      day_full9 = 9'd0;
    end else begin
      month9    = month_of(r3_8_r);
      day_full9 = r3_8_r - DAYS_BEFORE[month9] + 9'd1;
      day9      = day_full9[4:0];
    end
  end
  assign out_tdata_nxt = {7'd0, day9, month9, y8_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_full_r  <= 1'b0;
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      v3_r         <= 1'b0;
      v4_r         <= 1'b0;
      v5_r         <= 1'b0;
      v6_r         <= 1'b0;
      v7_r         <= 1'b0;
      v8_r         <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      skid_full_r <= skid_full_nxt;
      if (en) begin
        v1_r         <= src_valid;
        v2_r         <= v1_r;
        v3_r         <= v2_r;
        v4_r         <= v3_r;
        v5_r         <= v4_r;
        v6_r         <= v5_r;
        v7_r         <= v6_r;
        v8_r         <= v7_r;
        out_tvalid_r <= v8_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!en && in_tvalid && !skid_full_r) begin
      skid_r <= in_tdata;
    end
    if (en) begin
      e1_r        <= e1_nxt;
      e2_r        <= e1_r;
      qe2_r       <= qe2_nxt;
      e3_r        <= e2_r;
      qe3_r       <= qe2_r;
      p3_r        <= p3_nxt;
      d0_4_r      <= d0_4_nxt;
      q4_r        <= q4_nxt;
      y5_r        <= y5_nxt;
      x5_r        <= x5_nxt;
      ed5_r       <= d0_4_r[5:0];
      c5_r        <= c5_nxt;
      d2_5_r      <= d2_5_nxt;
      y6_r        <= y6_nxt;
      x6_r        <= x6_nxt;
      ed6_r       <= ed6_nxt;
      d2_6_r      <= d2_5_r;
      pr6_r       <= pr6_nxt;
      y7_r        <= y7_nxt;
      x7_r        <= x7_nxt;
      ed7_r       <= ed7_nxt;
      d3_7_r      <= d3_7_nxt;
      y8_r        <= y8_nxt;
      x8_r        <= x7_r;
      ed8_r       <= ed7_r;
      r3_8_r      <= r3_8_nxt;
      out_tdata_r <= out_tdata_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    v4_r |-> d0_4_r < DAYS_400Y)
    else $error("400-year remainder out of range");

  a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r |-> (out_tdata_r[27:24] >= 4'd1 && out_tdata_r[27:24] <= 4'd12))
    else $error("month out of range");

  a_day_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r |-> (out_tdata_r[32:28] != 5'd0 &&
                      !(out_tdata_r[27:24] == 4'd2 && out_tdata_r[32:28] > 5'd29)))
    else $error("day out of range");

  a_skid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_full_r && !en) |=> (skid_full_r && $stable(skid_r)))
    else $error("skid word lost during stall");

endmodule

// ===== verif/gregorian_date_from_day_number_tb.sv =====
// Testbench for the day-number to Gregorian date converter: stream driver, predictor, checker.
`timescale 1ns / 100ps

module gregorian_date_from_day_number_tb;

  typedef struct packed {
    logic [23:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
  } gdate_t;

  class date_checker;
    localparam longint JAN1_YEAR0 = 1721060;
    localparam longint QUAD_CENT  = 146097;
    localparam longint CENTURY    = 36524;
    localparam longint OLYMPIAD   = 1461;
    localparam longint YEAR_LEN   = 365;
    localparam longint MAR1_LEAP  = 60;
    localparam longint MAR1_PLAIN = 59;
    localparam longint JAN_LEN    = 31;

    gdate_t expected_dates[$];
    int     mismatches;
    int     dates_checked;
    int     days_sent;
    int     month_start[14];

    function new();
      month_start = '{0, 0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334, 365};
      mismatches    = 0;
      dates_checked = 0;
      days_sent     = 0;
    endfunction

    function gdate_t predict_date(logic [31:0] day_number);
      gdate_t r;
      longint d;
      longint q;
      longint yr;
      int     m;
      d = longint'($signed(day_number)) - JAN1_YEAR0;
      q = d / QUAD_CENT;
      if (d % QUAD_CENT < 0) begin
        q--;
      end
      d  -= q * QUAD_CENT;
      yr  = q * 400;
      m   = 0;
      // Jan/Feb are split off at every cycle level so the leap day lands right
      if (d >= MAR1_LEAP) begin
        d--;
        yr += (d / CENTURY) * 100;
        d   = d % CENTURY;
        if (d >= MAR1_PLAIN) begin
          d++;
          yr += (d / OLYMPIAD) * 4;
          d   = d % OLYMPIAD;
          if (d >= MAR1_LEAP) begin
            d--;
            yr += d / YEAR_LEN;
            d   = d % YEAR_LEN;
            m   = 1;
            while (m < 12 && d >= month_start[m + 1]) begin
              m++;
            end
            d = d - month_start[m] + 1;
          end
        end
      end
      if (m == 0) begin
        if (d < JAN_LEN) begin
          m = 1;
          d = d + 1;
        end else begin
          m = 2;
          d = d - (JAN_LEN - 1);
        end
      end
      r.year  = yr[23:0];
      r.month = m[3:0];
      r.day   = d[4:0];
      return r;
    endfunction

    function void note_day(logic [31:0] day_number);
      expected_dates.push_back(predict_date(day_number));
      days_sent++;
    endfunction

    function void check_date(logic [39:0] word);
      gdate_t want;
      gdate_t got;
      got = {word[23:0], word[27:24], word[32:28]};
      if (expected_dates.size() == 0) begin
        $display("%0t: unexpected date word %h", $time, word);
        mismatches++;
        return;
      end
      want = expected_dates.pop_front();
      dates_checked++;
      if (got.year !== want.year) begin
        $display("%0t: year mismatch, expected %0d, actual %0d", $time,
                 $signed(want.year), $signed(got.year));
        mismatches++;
      end
      if (got.month !== want.month) begin
        $display("%0t: month mismatch, expected %0d, actual %0d", $time, want.month, got.month);
        mismatches++;
      end
      if (got.day !== want.day) begin
        $display("%0t: day mismatch, expected %0d, actual %0d", $time, want.day, got.day);
        mismatches++;
      end
      if (word[39:33] !== 7'd0) begin
        $display("%0t: pad bits mismatch, expected 0, actual %h", $time, word[39:33]);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_dates.size();
    endfunction
  endclass

  localparam longint JAN1_Y0 = 1721060;
  localparam longint CYCLE   = 146097;
  localparam int     N_RAND  = 1450;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;    // day_number[31:0]
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;   // year[23:0], month[27:24], day[32:28], zero[39:33]

  date_checker sb;
  bit          calm;        // no idling on either side while set

  gregorian_date_from_day_number u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        sb.note_day(in_tdata);
      end
      if (out_tvalid && out_tready) begin
        sb.check_date(out_tdata);
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= calm || ($urandom_range(99) >= 36);
    end
  end

  task automatic send_day(logic [31:0] day_number);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 36) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= day_number;
    @(posedge clk);
    while (!in_tready) begin
      @(posedge clk);
    end
  endtask

  task automatic drain_dates();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) begin
      @(posedge clk);
    end
  endtask

  function automatic logic [31:0] random_day();
    longint v;
    longint offs [10] = '{0, 58, 59, 60, 365, 366, 36524, 36525, 36583, 36584};
    case ($urandom_range(9))
      0, 1, 2: v = $urandom;
      3, 4:    v = JAN1_Y0 + longint'($urandom_range(4000000)) - 2000000;
      5:       v = JAN1_Y0 + (longint'($urandom_range(29400)) - 14700) * CYCLE
                   + offs[$urandom_range(9)] + longint'($urandom_range(2)) - 1;
      6: begin
        if ($urandom_range(1)) begin
          v = 32'h8000_0000 + longint'($urandom_range(2000));
        end else begin
          v = 32'h7fff_ffff - longint'($urandom_range(2000));
        end
      end
      7:       v = 2000000 + longint'($urandom_range(600000));
      default: v = JAN1_Y0 + (longint'($urandom_range(8000)) - 4000) * 1461
                   + offs[$urandom_range(5)] + longint'($urandom_range(2)) - 1;
    endcase
    return v[31:0];
  endfunction

  initial begin
    longint directed [25];
    longint dn;
    directed = '{
      -2147483647 - 1, -2147483647, 2147483647, 0, -1, 1,
      JAN1_Y0, JAN1_Y0 + 31, JAN1_Y0 + 58, JAN1_Y0 + 59, JAN1_Y0 + 60,
      JAN1_Y0 + 365, JAN1_Y0 + 366, JAN1_Y0 + 1461 + 59,
      JAN1_Y0 + 36525 + 58, JAN1_Y0 + 36525 + 59,
      JAN1_Y0 + CYCLE - 1, JAN1_Y0 + CYCLE, JAN1_Y0 - 1,
      JAN1_Y0 - CYCLE, JAN1_Y0 - CYCLE - 1,
      2451545, 2299160, 2299161, 2440588
    };
    sb         = new();
    calm       = 1'b0;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    out_tready = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) begin
      dn = directed[i];
      send_day(dn[31:0]);
    end
    drain_dates();

    for (int i = 0; i < N_RAND; i++) begin
      calm = (i >= 600 && i < 850);
      if (i == 1000) begin
        drain_dates();
      end
      send_day(random_day());
    end
    @(negedge clk);
    in_tvalid <= 1'b0;
    calm = 1'b0;

    while (sb.pending() != 0) begin
      @(posedge clk);
    end
    repeat (20) @(posedge clk);

    $display("Sent %0d day numbers (edges of the 32-bit range, cycle and leap boundaries),",
             sb.days_sent);
    $display("checked %0d dates, %0d mismatches", sb.dates_checked, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("Timeout waiting for dates");
    $display("Test completed with failures");
    $finish;
  end

endmodule
